/* rtl/core/lncp_pkg.sv */
package lncp_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int SCREEN_BITS = 12;
    localparam int MAT_W       = 32;
    localparam int CFG_W       = 64;
    localparam int ORG_W       = 24;
    localparam int CLIP_W      = 41;
    localparam int DIFF_W      = CLIP_W + 1;
    localparam int QUOT_BITS   = 22;
    localparam int K_W         = SCREEN_BITS + 3;
    localparam int BASE_W      = SCREEN_BITS + 5;
    localparam int OUT_W       = 21;
    localparam int IDX_W       = 3;

    localparam logic signed [CLIP_W-1:0] W_MIN =
        CLIP_W'((((64'sd1) <<< FRAC_BITS) + 64'sd5) / 64'sd10);
    localparam logic signed [63:0] CLIP_MAX = ((64'sd1) <<< (CLIP_W - 1)) - 64'sd1;

    typedef enum logic [IDX_W-1:0] {
        REG_X_LO  = 3'd0,
        REG_X_HI  = 3'd1,
        REG_Y_LO  = 3'd2,
        REG_Y_HI  = 3'd3,
        REG_W_LO  = 3'd4,
        REG_W_HI  = 3'd5,
        REG_ORIG  = 3'd6,
        REG_VSIZE = 3'd7
    } t_cfg_idx;

    typedef logic [2:0][3:0][MAT_W-1:0] t_mat;

    typedef struct packed {
        logic signed [CLIP_W-1:0] x;
        logic signed [CLIP_W-1:0] y;
        logic signed [CLIP_W-1:0] w;
    } t_clip_pt;

    typedef struct packed {
        t_clip_pt a;
        t_clip_pt b;
    } t_mid;

    typedef struct packed {
        logic [K_W-1:0]    k;
        logic [BASE_W-1:0] base;
    } t_view;

    typedef struct packed {
        logic             vis;
        logic [OUT_W-1:0] sx;
        logic [OUT_W-1:0] sy;
        logic [OUT_W-1:0] ex;
        logic [OUT_W-1:0] ey;
    } t_res;

endpackage

/* rtl/core/lncp_front.sv */
module lncp_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    output logic                        o_full,
    input  logic signed [31:0]          i_start_x,
    input  logic signed [31:0]          i_start_y,
    input  logic signed [31:0]          i_start_z,
    input  logic signed [31:0]          i_end_x,
    input  logic signed [31:0]          i_end_y,
    input  logic signed [31:0]          i_end_z,
    input  lncp_pkg::t_mat              i_mat,
    output logic                        o_valid,
    output lncp_pkg::t_mid              o_pt,
    input  logic                        i_ready
);

    logic                  r_v1;
    logic                  r_v2;
    logic signed [63:0]    r_prod [2][3][3];
    lncp_pkg::t_mid        r_pt;
    lncp_pkg::t_mid        n_pt;
    logic                  adv1;
    logic                  adv2;
    logic signed [lncp_pkg::MAT_W-1:0] pts [2][3];
    logic signed [63:0]    sums [2][3];
    lncp_pkg::t_clip_pt    ep [2];

    function automatic logic signed [lncp_pkg::CLIP_W-1:0] sat_clip(
        input logic signed [63:0] v
    );
        if (v > lncp_pkg::CLIP_MAX) begin
            return lncp_pkg::CLIP_W'(lncp_pkg::CLIP_MAX);
        end else if (v < -lncp_pkg::CLIP_MAX) begin
            return lncp_pkg::CLIP_W'(-lncp_pkg::CLIP_MAX);
        end
        return lncp_pkg::CLIP_W'(v);
    endfunction

    assign pts[0][0] = i_start_x;
    assign pts[0][1] = i_start_y;
    assign pts[0][2] = i_start_z;
    assign pts[1][0] = i_end_x;
    assign pts[1][1] = i_end_y;
    assign pts[1][2] = i_end_z;

    assign adv2   = !r_v2 || i_ready;
    assign adv1   = !r_v1 || adv2;
    assign o_full = !adv1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (adv1) begin
                r_v1 <= i_push;
            end
            if (adv2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            for (int e = 0; e < 2; e++) begin
                for (int r = 0; r < 3; r++) begin
                    for (int c = 0; c < 3; c++) begin
                        r_prod[e][r][c] <= 64'(pts[e][c]) * 64'($signed(i_mat[r][c]));
                    end
                end
            end
        end
    end

    always_comb begin
        for (int e = 0; e < 2; e++) begin
            for (int r = 0; r < 3; r++) begin
                sums[e][r] = (r_prod[e][r][0] >>> lncp_pkg::FRAC_BITS)
                           + (r_prod[e][r][1] >>> lncp_pkg::FRAC_BITS)
                           + (r_prod[e][r][2] >>> lncp_pkg::FRAC_BITS)
                           + 64'($signed(i_mat[r][3]));
            end
            ep[e].x = sat_clip(sums[e][0]);
            ep[e].y = sat_clip(sums[e][1]);
            ep[e].w = sat_clip(sums[e][2]);
        end
        n_pt.a = ep[0];
        n_pt.b = ep[1];
    end

    always_ff @(posedge i_clk) begin
        if (adv2) begin
            r_pt <= n_pt;
        end
    end

    assign o_valid = r_v2;
    assign o_pt    = r_pt;

endmodule

/* rtl/core/lncp_queue.sv */
module lncp_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    output logic           o_full,
    input  lncp_pkg::t_mid i_data,
    input  logic           i_pop,
    output logic           o_empty,
    output lncp_pkg::t_mid o_data
);

    lncp_pkg::t_mid r_mem [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    logic           do_push;
    logic           do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= !r_wp;
            end
            if (do_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(do_push) - 2'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

/* rtl/core/lncp_clip.sv */
module lncp_clip (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    input  logic           i_valid,
    input  lncp_pkg::t_mid i_pt,
    output logic           o_valid,
    output logic           o_vis,
    output lncp_pkg::t_mid o_pt
);

    localparam int FB = lncp_pkg::FRAC_BITS;
    localparam int CW = lncp_pkg::CLIP_W;
    localparam int DW = lncp_pkg::DIFF_W;
    localparam int PW = DW + FB;

    typedef struct packed {
        logic                 vis;
        logic                 clip;
        logic                 p_is_a;
        logic signed [CW-1:0] px;
        logic signed [CW-1:0] py;
        logic signed [CW-1:0] qx;
        logic signed [CW-1:0] qy;
        logic signed [CW-1:0] qw;
        logic signed [DW-1:0] dx;
        logic signed [DW-1:0] dy;
        logic [DW-1:0]        n;
        logic [DW-1:0]        d;
        logic [FB-1:0]        t;
    } t_cs;

    logic [FB:0]   r_v;
    t_cs           r_st [FB+1];
    logic          r_vm;
    t_cs           r_ms;
    logic [PW-1:0] r_prx;
    logic [PW-1:0] r_pry;
    logic          r_vo;
    logic          r_viso;
    lncp_pkg::t_mid r_out;

    t_cs                n_s0;
    lncp_pkg::t_clip_pt pp;
    lncp_pkg::t_clip_pt qq;
    logic               va;
    logic               vb;
    logic [DW-1:0]      ax;
    logic [DW-1:0]      ay;
    logic [DW-1:0]      mx;
    logic [DW-1:0]      my;
    logic signed [DW-1:0] nx;
    logic signed [DW-1:0] ny;
    lncp_pkg::t_clip_pt np;
    lncp_pkg::t_clip_pt nq;
    lncp_pkg::t_mid     n_out;

    function automatic t_cs div_step(input t_cs s);
        t_cs         o;
        logic [DW:0] n2;
        o  = s;
        n2 = {s.n, 1'b0};
        if (n2 >= {1'b0, s.d}) begin
            o.n = DW'(n2 - {1'b0, s.d});
            o.t = {s.t[FB-2:0], 1'b1};
        end else begin
            o.n = n2[DW-1:0];
            o.t = {s.t[FB-2:0], 1'b0};
        end
        return o;
    endfunction

    always_comb begin
        va = i_pt.a.w > lncp_pkg::W_MIN;
        vb = i_pt.b.w > lncp_pkg::W_MIN;
        pp = va ? i_pt.b : i_pt.a;
        qq = va ? i_pt.a : i_pt.b;
        n_s0.vis    = va || vb;
        n_s0.clip   = va ^ vb;
        n_s0.p_is_a = !va;
        n_s0.px     = pp.x;
        n_s0.py     = pp.y;
        n_s0.qx     = qq.x;
        n_s0.qy     = qq.y;
        n_s0.qw     = qq.w;
        n_s0.dx     = DW'(qq.x) - DW'(pp.x);
        n_s0.dy     = DW'(qq.y) - DW'(pp.y);
        n_s0.n      = unsigned'(DW'(lncp_pkg::W_MIN) - DW'(pp.w));
        n_s0.d      = unsigned'(DW'(qq.w) - DW'(pp.w));
        n_s0.t      = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= '0;
            r_vm <= 1'b0;
            r_vo <= 1'b0;
        end else if (i_adv) begin
            r_v  <= {r_v[FB-1:0], i_valid};
            r_vm <= r_v[FB];
            r_vo <= r_vm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_st[0] <= n_s0;
            for (int i = 0; i < FB; i++) begin
                r_st[i+1] <= div_step(r_st[i]);
            end
        end
    end

    assign ax = r_st[FB].dx[DW-1] ? unsigned'(-r_st[FB].dx) : unsigned'(r_st[FB].dx);
    assign ay = r_st[FB].dy[DW-1] ? unsigned'(-r_st[FB].dy) : unsigned'(r_st[FB].dy);

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_ms  <= r_st[FB];
            r_prx <= PW'(ax) * PW'(r_st[FB].t);
            r_pry <= PW'(ay) * PW'(r_st[FB].t);
        end
    end

    always_comb begin
        mx = r_prx[PW-1:FB];
        my = r_pry[PW-1:FB];
        nx = DW'(r_ms.px) + (r_ms.dx[DW-1] ? -signed'(mx) : signed'(mx));
        ny = DW'(r_ms.py) + (r_ms.dy[DW-1] ? -signed'(my) : signed'(my));
        nq.x = r_ms.qx;
        nq.y = r_ms.qy;
        nq.w = r_ms.qw;
        if (r_ms.clip) begin
            np.x = CW'(nx);
            np.y = CW'(ny);
            np.w = lncp_pkg::W_MIN;
        end else begin
            np.x = r_ms.px;
            np.y = r_ms.py;
            np.w = CW'(DW'(r_ms.qw) - r_ms.dx + r_ms.dx - DW'(r_ms.qw))
                 + CW'(DW'(r_ms.qw) - signed'(r_ms.d));
        end
        n_out.a = r_ms.p_is_a ? np : nq;
        n_out.b = r_ms.p_is_a ? nq : np;
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_viso <= r_ms.vis;
            r_out  <= n_out;
        end
    end

    assign o_valid = r_vo;
    assign o_vis   = r_viso;
    assign o_pt    = r_out;

endmodule

/* rtl/core/lncp_screen.sv */
module lncp_screen (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_adv,
    input  logic                                i_valid,
    input  logic                                i_vis,
    input  logic                                i_sub,
    input  logic signed [lncp_pkg::CLIP_W-1:0]  i_v,
    input  logic signed [lncp_pkg::CLIP_W-1:0]  i_w,
    input  lncp_pkg::t_view                     i_view,
    output logic                                o_valid,
    output logic                                o_vis,
    output logic [lncp_pkg::OUT_W-1:0]          o_res
);

    localparam int CW    = lncp_pkg::CLIP_W;
    localparam int QB    = lncp_pkg::QUOT_BITS;
    localparam int KW    = lncp_pkg::K_W;
    localparam int RKW   = CW + KW;
    localparam int QKW   = QB + KW;
    localparam int MW    = QB + 1;
    localparam int SW    = lncp_pkg::BASE_W + 8;
    localparam int OW    = lncp_pkg::OUT_W;

    localparam logic [MW-1:0]        QMAX   = MW'(1) << QB;
    localparam logic signed [SW-1:0] OUT_HI = (SW'(1) <<< (OW - 1)) - SW'(1);
    localparam logic signed [SW-1:0] OUT_LO = -(SW'(1) <<< (OW - 1));

    typedef struct packed {
        logic          vis;
        logic          neg;
        logic          sat;
        logic [CW-1:0] w;
        logic [CW-1:0] r;
        logic [QB-1:0] lo;
        logic [QB-1:0] q;
    } t_qs;

    typedef struct packed {
        logic           vis;
        logic           neg;
        logic           sat;
        logic [CW-1:0]  w;
        logic [CW-1:0]  r;
        logic [KW-1:0]  lo;
        logic [KW-1:0]  q;
        logic [QKW-1:0] qk;
    } t_fs;

    logic [QB:0]   r_va;
    t_qs           r_a [QB+1];
    logic [KW:0]   r_vb;
    t_fs           r_b [KW+1];
    logic          r_vo;
    logic          r_viso;
    logic [OW-1:0] r_res;

    t_qs              n_a0;
    t_fs              n_b0;
    logic [CW-1:0]    av;
    logic [CW-1:0]    hi;
    logic [RKW-1:0]   rk;
    logic [QKW:0]     msum;
    logic [MW-1:0]    mag;
    logic signed [SW-1:0] sum;
    logic [OW-1:0]    n_res;

    function automatic t_qs q_step(input t_qs s);
        t_qs         o;
        logic [CW:0] r2;
        o    = s;
        r2   = {s.r, s.lo[QB-1]};
        o.lo = {s.lo[QB-2:0], 1'b0};
        if (r2 >= {1'b0, s.w}) begin
            o.r = CW'(r2 - {1'b0, s.w});
            o.q = {s.q[QB-2:0], 1'b1};
        end else begin
            o.r = r2[CW-1:0];
            o.q = {s.q[QB-2:0], 1'b0};
        end
        return o;
    endfunction

    function automatic t_fs f_step(input t_fs s);
        t_fs         o;
        logic [CW:0] r2;
        o    = s;
        r2   = {s.r, s.lo[KW-1]};
        o.lo = {s.lo[KW-2:0], 1'b0};
        if (r2 >= {1'b0, s.w}) begin
            o.r = CW'(r2 - {1'b0, s.w});
            o.q = {s.q[KW-2:0], 1'b1};
        end else begin
            o.r = r2[CW-1:0];
            o.q = {s.q[KW-2:0], 1'b0};
        end
        return o;
    endfunction

    always_comb begin
        av = i_v[CW-1] ? unsigned'(-i_v) : unsigned'(i_v);
        hi = av >> QB;
        n_a0.vis = i_vis;
        n_a0.neg = i_v[CW-1];
        n_a0.w   = unsigned'(i_w);
        n_a0.sat = hi >= unsigned'(i_w);
        n_a0.r   = hi;
        n_a0.lo  = av[QB-1:0];
        n_a0.q   = '0;
    end

    always_comb begin
        rk       = RKW'(r_a[QB].r) * RKW'(i_view.k);
        n_b0.vis = r_a[QB].vis;
        n_b0.neg = r_a[QB].neg;
        n_b0.sat = r_a[QB].sat;
        n_b0.w   = r_a[QB].w;
        n_b0.r   = rk[RKW-1:KW];
        n_b0.lo  = rk[KW-1:0];
        n_b0.q   = '0;
        n_b0.qk  = QKW'(r_a[QB].q) * QKW'(i_view.k);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= '0;
            r_vb <= '0;
            r_vo <= 1'b0;
        end else if (i_adv) begin
            r_va <= {r_va[QB-1:0], i_valid};
            r_vb <= {r_vb[KW-1:0], r_va[QB]};
            r_vo <= r_vb[KW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_a[0] <= n_a0;
            for (int i = 0; i < QB; i++) begin
                r_a[i+1] <= q_step(r_a[i]);
            end
            r_b[0] <= n_b0;
            for (int i = 0; i < KW; i++) begin
                r_b[i+1] <= f_step(r_b[i]);
            end
        end
    end

    always_comb begin
        msum = (QKW+1)'(r_b[KW].qk) + (QKW+1)'(r_b[KW].q);
        if (r_b[KW].sat || msum > (QKW+1)'(QMAX)) begin
            mag = QMAX;
        end else begin
            mag = msum[MW-1:0];
        end
        if (r_b[KW].neg ^ i_sub) begin
            sum = SW'(i_view.base) - SW'(mag);
        end else begin
            sum = SW'(i_view.base) + SW'(mag);
        end
        if (!r_b[KW].vis) begin
            n_res = '0;
        end else if (sum > OUT_HI) begin
            n_res = OW'(OUT_HI);
        end else if (sum < OUT_LO) begin
            n_res = OW'(OUT_LO);
        end else begin
            n_res = OW'(sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_viso <= r_b[KW].vis;
            r_res  <= n_res;
        end
    end

    assign o_valid = r_vo;
    assign o_vis   = r_viso;
    assign o_res   = r_res;

endmodule

/* rtl/core/line_near_clip_project_core.sv */
// Line near-plane clip and viewport projection.
// Input queue side: drive the six endpoint coordinates (signed Q16.16) with
// push; a word is taken on a clock edge where push is high and full is low.
// Result queue side: while empty is low the oldest result sits on o_visible
// and the four Q17.4 screen coordinates; pop takes it on an edge where pop is
// high and empty is low. Invisible lines return zero coordinates.
// Configuration: write one register per edge with i_cfg_valid (o_cfg_ready is
// always high); write only while no line is in flight.
// Throughput: one line per cycle while the result queue is not held full. The
// path runs through the 16-step clip divider and the 22-step plus 15-step
// screen dividers, each resolving one quotient bit per stage.
// A two-word queue decouples the transform front end from the clip/projection
// back end. When the receiver stops popping, the result queue fills, the back
// end holds, the middle queue fills, and full rises; no word is lost.
// Reset (synchronous, active low) empties all queues and restores pass-through
// x/y rows, a constant-1.0 w row, origin (0,0) and a 640 x 480 viewport.
module line_near_clip_project_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic signed [31:0]              i_start_x,
    input  logic signed [31:0]              i_start_y,
    input  logic signed [31:0]              i_start_z,
    input  logic signed [31:0]              i_end_x,
    input  logic signed [31:0]              i_end_y,
    input  logic signed [31:0]              i_end_z,
    output logic                            empty,
    input  logic                            pop,
    output logic                            o_visible,
    output logic signed [20:0]              o_start_screen_x,
    output logic signed [20:0]              o_start_screen_y,
    output logic signed [20:0]              o_end_screen_x,
    output logic signed [20:0]              o_end_screen_y,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [lncp_pkg::IDX_W-1:0]      i_cfg_index,
    input  logic [lncp_pkg::CFG_W-1:0]      i_cfg_data
);

    localparam int SB = lncp_pkg::SCREEN_BITS;

    logic [lncp_pkg::CFG_W-1:0] r_x_lo;
    logic [lncp_pkg::CFG_W-1:0] r_x_hi;
    logic [lncp_pkg::CFG_W-1:0] r_y_lo;
    logic [lncp_pkg::CFG_W-1:0] r_y_hi;
    logic [lncp_pkg::CFG_W-1:0] r_w_lo;
    logic [lncp_pkg::CFG_W-1:0] r_w_hi;
    logic [lncp_pkg::ORG_W-1:0] r_orig;
    logic [lncp_pkg::ORG_W-1:0] r_vsize;

    lncp_pkg::t_res r_oq [2];
    logic           r_owp;
    logic           r_orp;
    logic [1:0]     r_ocnt;

    lncp_pkg::t_mat  mat;
    lncp_pkg::t_view view_x;
    lncp_pkg::t_view view_y;
    logic [SB-1:0]   vw;
    logic [SB-1:0]   vh;
    logic [SB-1:0]   vwc;
    logic [SB-1:0]   vhc;

    logic            f_valid;
    lncp_pkg::t_mid  f_pt;
    logic            q_full;
    logic            q_empty;
    lncp_pkg::t_mid  q_pt;
    logic            adv;
    logic            c_valid;
    logic            c_vis;
    lncp_pkg::t_mid  c_pt;
    logic            l_valid;
    logic            l_vis;
    logic [lncp_pkg::OUT_W-1:0] l_res [4];
    logic            o_push;
    logic            o_pop;
    lncp_pkg::t_res  n_res;
    lncp_pkg::t_res  head;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_lo  <= 64'd65536;
            r_x_hi  <= 64'd0;
            r_y_lo  <= 64'd281474976710656;
            r_y_hi  <= 64'd0;
            r_w_lo  <= 64'd0;
            r_w_hi  <= 64'd281474976710656;
            r_orig  <= 24'd0;
            r_vsize <= 24'd1966720;
        end else if (i_cfg_valid) begin
            case (lncp_pkg::t_cfg_idx'(i_cfg_index))
                lncp_pkg::REG_X_LO: begin
                    r_x_lo <= i_cfg_data;
                end
                lncp_pkg::REG_X_HI: begin
                    r_x_hi <= i_cfg_data;
                end
                lncp_pkg::REG_Y_LO: begin
                    r_y_lo <= i_cfg_data;
                end
                lncp_pkg::REG_Y_HI: begin
                    r_y_hi <= i_cfg_data;
                end
                lncp_pkg::REG_W_LO: begin
                    r_w_lo <= i_cfg_data;
                end
                lncp_pkg::REG_W_HI: begin
                    r_w_hi <= i_cfg_data;
                end
                lncp_pkg::REG_ORIG: begin
                    r_orig <= i_cfg_data[lncp_pkg::ORG_W-1:0];
                end
                lncp_pkg::REG_VSIZE: begin
                    r_vsize <= i_cfg_data[lncp_pkg::ORG_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        mat[0] = {r_x_hi[63:32], r_x_hi[31:0], r_x_lo[63:32], r_x_lo[31:0]};
        mat[1] = {r_y_hi[63:32], r_y_hi[31:0], r_y_lo[63:32], r_y_lo[31:0]};
        mat[2] = {r_w_hi[63:32], r_w_hi[31:0], r_w_lo[63:32], r_w_lo[31:0]};
        vw  = r_vsize[SB-1:0];
        vh  = r_vsize[2*SB-1:SB];
        vwc = (vw < SB'(4)) ? SB'(4) : vw;
        vhc = (vh < SB'(4)) ? SB'(4) : vh;
        view_x.k    = {vwc, 3'b000};
        view_y.k    = {vhc, 3'b000};
        view_x.base = lncp_pkg::BASE_W'({r_orig[SB-1:0], 4'b0000})
                    + lncp_pkg::BASE_W'(view_x.k);
        view_y.base = lncp_pkg::BASE_W'({r_orig[2*SB-1:SB], 4'b0000})
                    + lncp_pkg::BASE_W'(view_y.k);
    end

    lncp_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .o_full    (full),
        .i_start_x (i_start_x),
        .i_start_y (i_start_y),
        .i_start_z (i_start_z),
        .i_end_x   (i_end_x),
        .i_end_y   (i_end_y),
        .i_end_z   (i_end_z),
        .i_mat     (mat),
        .o_valid   (f_valid),
        .o_pt      (f_pt),
        .i_ready   (!q_full)
    );

    lncp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .o_full  (q_full),
        .i_data  (f_pt),
        .i_pop   (adv),
        .o_empty (q_empty),
        .o_data  (q_pt)
    );

    assign adv = !l_valid || (r_ocnt != 2'd2);

    lncp_clip u_clip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (!q_empty),
        .i_pt    (q_pt),
        .o_valid (c_valid),
        .o_vis   (c_vis),
        .o_pt    (c_pt)
    );

    lncp_screen u_sx (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (c_valid),
        .i_vis   (c_vis),
        .i_sub   (1'b0),
        .i_v     (c_pt.a.x),
        .i_w     (c_pt.a.w),
        .i_view  (view_x),
        .o_valid (l_valid),
        .o_vis   (l_vis),
        .o_res   (l_res[0])
    );

    lncp_screen u_sy (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (c_valid),
        .i_vis   (c_vis),
        .i_sub   (1'b1),
        .i_v     (c_pt.a.y),
        .i_w     (c_pt.a.w),
        .i_view  (view_y),
        .o_valid (),
        .o_vis   (),
        .o_res   (l_res[1])
    );

    lncp_screen u_ex (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (c_valid),
        .i_vis   (c_vis),
        .i_sub   (1'b0),
        .i_v     (c_pt.b.x),
        .i_w     (c_pt.b.w),
        .i_view  (view_x),
        .o_valid (),
        .o_vis   (),
        .o_res   (l_res[2])
    );

    lncp_screen u_ey (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (c_valid),
        .i_vis   (c_vis),
        .i_sub   (1'b1),
        .i_v     (c_pt.b.y),
        .i_w     (c_pt.b.w),
        .i_view  (view_y),
        .o_valid (),
        .o_vis   (),
        .o_res   (l_res[3])
    );

    assign o_push    = l_valid && (r_ocnt != 2'd2);
    assign o_pop     = pop && !empty;
    assign n_res.vis = l_vis;
    assign n_res.sx  = l_res[0];
    assign n_res.sy  = l_res[1];
    assign n_res.ex  = l_res[2];
    assign n_res.ey  = l_res[3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owp  <= 1'b0;
            r_orp  <= 1'b0;
            r_ocnt <= 2'd0;
        end else begin
            if (o_push) begin
                r_owp <= !r_owp;
            end
            if (o_pop) begin
                r_orp <= !r_orp;
            end
            r_ocnt <= r_ocnt + 2'(o_push) - 2'(o_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_push) begin
            r_oq[r_owp] <= n_res;
        end
    end

    assign empty            = (r_ocnt == 2'd0);
    assign head             = r_oq[r_orp];
    assign o_visible        = head.vis;
    assign o_start_screen_x = $signed(head.sx);
    assign o_start_screen_y = $signed(head.sy);
    assign o_end_screen_x   = $signed(head.ex);
    assign o_end_screen_y   = $signed(head.ey);

endmodule
